[rtl/core/ata_pkg.sv]
// shared types, widths and constants for the tilt-angle filter
// no dependencies
`default_nettype none
package ata_pkg;

    localparam int unsigned AXIS_W  = 16;
    localparam int unsigned ANGLE_W = 24;
    localparam int unsigned ROOT_W  = 24;
    localparam int unsigned RAD_W   = 2 * ROOT_W;
    localparam int unsigned ALPHA_W = 16;
    localparam int unsigned OUT_W   = 16;

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 24'sd5898240;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic signed [OUT_W-1:0] pitch_deg;
        logic signed [OUT_W-1:0] roll_deg;
    } t_angles;

    // rounded atan(2^-i) in degrees times 65536
    function automatic logic [ANGLE_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:  v = 24'd2949120;
            5'd1:  v = 24'd1740967;
            5'd2:  v = 24'd919879;
            5'd3:  v = 24'd466945;
            5'd4:  v = 24'd234379;
            5'd5:  v = 24'd117304;
            5'd6:  v = 24'd58666;
            5'd7:  v = 24'd29335;
            5'd8:  v = 24'd14668;
            5'd9:  v = 24'd7334;
            5'd10: v = 24'd3667;
            5'd11: v = 24'd1833;
            5'd12: v = 24'd917;
            5'd13: v = 24'd458;
            5'd14: v = 24'd229;
            5'd15: v = 24'd115;
            5'd16: v = 24'd57;
            5'd17: v = 24'd29;
            5'd18: v = 24'd14;
            5'd19: v = 24'd7;
            5'd20: v = 24'd4;
            5'd21: v = 24'd2;
            5'd22: v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/core/ata_stream_if.sv]
// valid/ready word channel with a typed payload
// no dependencies
`default_nettype none
interface ata_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/accel_tilt_angle_filter.sv]
// steps from accepted word to result word: square, serial root bits, cordic load,
// CORDIC_ITERATIONS rotations, seed, filter, output register
// a seeding word skips the filter states; pitch and roll run in two tilt units side by side
// one word at a time: a new word is accepted only while idle, so the serial root and cordic
// loop set the word rate, which drops further while the previous result word waits for ready
// reset: synchronous active low, clears smoothed angles to zero, alpha to 3277
`default_nettype none
module accel_tilt_angle_filter #(
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ata_stream_if.sink   i_in,
    ata_stream_if.sink   i_cfg,
    ata_stream_if.source o_out
);
    localparam int unsigned AW = ata_pkg::ANGLE_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CALC = 7'b0000010,
        S_MULP = 7'b0000100,
        S_ADDP = 7'b0001000,
        S_MULR = 7'b0010000,
        S_ADDR = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [ata_pkg::ALPHA_W-1:0] r_alpha;
    logic signed [AW-1:0] r_s_pitch, r_s_roll;
    logic signed [AW-1:0] tilt_pitch, tilt_roll;
    logic                 done_p, done_r;
    logic signed [AW:0]   diff;
    logic signed [AW+17:0] r_prod;
    logic signed [AW+1:0] step, upd, sel_s;
    logic signed [AW-1:0] upd_c;
    logic                 r_out_valid;
    ata_pkg::t_angles     r_out;
    logic signed [AW:0]   q_p, q_r;
    logic                 accept;
    ata_pkg::t_sample     smp;

    assign smp    = i_in.data;
    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);

    // alpha register, written only while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ata_pkg::ALPHA_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_alpha <= i_cfg.data;
        end
    end

    // pitch = atan2(x, |y,z|), roll = atan2(y, |x,z|)
    ata_tilt #(.ITERATIONS(CORDIC_ITERATIONS)) u_tilt_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (smp.accel_x),
        .i_a     (smp.accel_y),
        .i_b     (smp.accel_z),
        .o_done  (done_p),
        .o_angle (tilt_pitch)
    );

    ata_tilt #(.ITERATIONS(CORDIC_ITERATIONS)) u_tilt_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (smp.accel_y),
        .i_a     (smp.accel_x),
        .i_b     (smp.accel_z),
        .o_done  (done_r),
        .o_angle (tilt_roll)
    );

    // shared filter multiplier: alpha * (raw - s), pitch then roll
    assign diff = (r_state == S_MULP) ? (AW+1)'(tilt_pitch) - (AW+1)'(r_s_pitch)
                                      : (AW+1)'(tilt_roll)  - (AW+1)'(r_s_roll);
    assign sel_s = (r_state == S_ADDP) ? (AW+2)'(r_s_pitch) : (AW+2)'(r_s_roll);
    // rounded floor shift by 16
    assign step  = (AW+2)'((r_prod + (AW+18)'(32768)) >>> 16);
    assign upd   = sel_s + step;

    always_comb begin
        if (upd > (AW+2)'(ata_pkg::ANGLE_LIMIT)) begin
            upd_c = ata_pkg::ANGLE_LIMIT;
        end else if (upd < -(AW+2)'(ata_pkg::ANGLE_LIMIT)) begin
            upd_c = -ata_pkg::ANGLE_LIMIT;
        end else begin
            upd_c = AW'(upd);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_CALC;
            S_CALC: begin
                if (done_p) begin
                    n_state = (r_s_pitch == '0 && r_s_roll == '0) ? S_OUT : S_MULP;
                end
            end
            S_MULP: n_state = S_ADDP;
            S_ADDP: n_state = S_MULR;
            S_MULR: n_state = S_ADDR;
            S_ADDR: n_state = S_OUT;
            S_OUT:  if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_s_pitch   <= '0;
            r_s_roll    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // seed both angles when the filter is still at zero
            if (r_state == S_CALC && done_p && r_s_pitch == '0 && r_s_roll == '0) begin
                r_s_pitch <= tilt_pitch;
                r_s_roll  <= tilt_roll;
            end
            if (r_state == S_ADDP) r_s_pitch <= upd_c;
            if (r_state == S_ADDR) r_s_roll  <= upd_c;
            if (r_state == S_OUT && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MULP || r_state == S_MULR) begin
            r_prod <= $signed({1'b0, r_alpha}) * diff;
        end
    end

    // q8.8 output with round half up
    assign q_p = ((AW+1)'(r_s_pitch) + (AW+1)'(128)) >>> 8;
    assign q_r = ((AW+1)'(r_s_roll)  + (AW+1)'(128)) >>> 8;

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || o_out.ready)) begin
            r_out.pitch_deg <= q_p[ata_pkg::OUT_W-1:0];
            r_out.roll_deg  <= q_r[ata_pkg::OUT_W-1:0];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // both tilt units run in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_p == done_r)
        else $error("tilt units out of step");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_pitch <= ata_pkg::ANGLE_LIMIT) && (r_s_pitch >= -ata_pkg::ANGLE_LIMIT))
        else $error("smoothed pitch out of range");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_roll <= ata_pkg::ANGLE_LIMIT) && (r_s_roll >= -ata_pkg::ANGLE_LIMIT))
        else $error("smoothed roll out of range");

    a_accept_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CALC))
        else $error("accepted word did not start calculation");
endmodule
`default_nettype wire

[rtl/core/ata_isqrt.sv]
// bit-serial restoring integer square root, one result bit per cycle
// depends on ata_pkg
`default_nettype none
module ata_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ata_pkg::RAD_W-1:0]   i_value,
    output logic                             o_done,
    output logic [ata_pkg::ROOT_W-1:0]       o_root
);
    localparam int unsigned RW = ata_pkg::ROOT_W;

    logic [ata_pkg::RAD_W-1:0] r_val;
    logic [RW+1:0]             r_rem;
    logic [RW-1:0]             r_root;
    logic [4:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [RW+3:0]             acc;
    logic [RW+3:0]             trial;

    // bring down two radicand bits, try the next root bit
    assign acc   = {r_rem, r_val[ata_pkg::RAD_W-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'(RW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 5'(RW - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[ata_pkg::RAD_W-3:0], 2'b00};
            r_cnt <= r_cnt + 5'd1;
            if (acc >= trial) begin
                r_rem  <= (RW+2)'(acc - trial);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= (RW+2)'(acc);
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

[rtl/core/ata_cordic.sv]
// iterative vectoring cordic, one micro-rotation per cycle
// depends on ata_pkg
`default_nettype none
module ata_cordic #(
    parameter int unsigned ITERATIONS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [ata_pkg::ROOT_W-1:0]        i_x0,
    input  wire logic signed [ata_pkg::ANGLE_W-1:0] i_y0,
    output logic                                   o_done,
    output logic signed [ata_pkg::ANGLE_W-1:0]     o_angle
);
    localparam int unsigned IW = $clog2(ITERATIONS);
    localparam int unsigned XW = 27;
    localparam int unsigned ZW = ata_pkg::ANGLE_W + 1;

    logic signed [XW-1:0] r_x, r_y, dx, dy, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z, step;
    logic [IW-1:0]        r_i;
    logic                 r_busy, r_done, r_zero;
    logic signed [ata_pkg::ANGLE_W-1:0] r_angle;
    logic                 last;

    assign dx   = r_y >>> 5'(r_i);
    assign dy   = r_x >>> 5'(r_i);
    assign step = ZW'(signed'({1'b0, ata_pkg::atan_lut(5'(r_i))}));
    assign last = (r_i == IW'(ITERATIONS - 1));

    always_comb begin
        if (!r_y[XW-1]) begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + step;
        end else begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= XW'(signed'({1'b0, i_x0}));
            r_y    <= XW'(i_y0);
            r_z    <= '0;
            r_i    <= '0;
            r_zero <= (i_x0 == '0) && (i_y0 == '0);
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_i <= r_i + IW'(1);
            if (last) begin
                if (r_zero) begin
                    r_angle <= '0;
                end else if (n_z > ZW'(ata_pkg::ANGLE_LIMIT)) begin
                    r_angle <= ata_pkg::ANGLE_LIMIT;
                end else if (n_z < -ZW'(ata_pkg::ANGLE_LIMIT)) begin
                    r_angle <= -ata_pkg::ANGLE_LIMIT;
                end else begin
                    r_angle <= ata_pkg::ANGLE_W'(n_z);
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;
endmodule
`default_nettype wire

[rtl/core/ata_tilt.sv]
// one tilt angle: sum of squares, serial square root, cordic
// depends on ata_pkg, ata_isqrt, ata_cordic
`default_nettype none
module ata_tilt #(
    parameter int unsigned ITERATIONS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [ata_pkg::AXIS_W-1:0]  i_num,
    input  wire logic signed [ata_pkg::AXIS_W-1:0]  i_a,
    input  wire logic signed [ata_pkg::AXIS_W-1:0]  i_b,
    output logic                                    o_done,
    output logic signed [ata_pkg::ANGLE_W-1:0]      o_angle
);
    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_SQB  = 4'b0010,
        T_ROOT = 4'b0100,
        T_ROT  = 4'b1000
    } t_tstate;

    t_tstate r_state, n_state;
    logic signed [ata_pkg::AXIS_W-1:0] r_num, r_b;
    logic [31:0] r_sq, bb, sum;
    logic        root_done;
    logic [ata_pkg::ROOT_W-1:0] root;
    logic signed [ata_pkg::ANGLE_W-1:0] y0;
    logic signed [2*ata_pkg::AXIS_W-1:0] prod;

    assign prod = (r_state == T_SQB) ? r_b * r_b : i_a * i_a;
    assign bb   = 32'(unsigned'(prod));
    assign sum  = r_sq + bb;
    assign y0   = {r_num, 8'h00};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: if (i_start) n_state = T_SQB;
            T_SQB:  n_state = T_ROOT;
            T_ROOT: if (root_done) n_state = T_ROT;
            T_ROT:  if (o_done) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_IDLE && i_start) begin
            r_num <= i_num;
            r_b   <= i_b;
            r_sq  <= bb;
        end
    end

    ata_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_SQB),
        .i_value ({sum[ata_pkg::RAD_W-17:0], 16'h0000}),
        .o_done  (root_done),
        .o_root  (root)
    );

    ata_cordic #(.ITERATIONS(ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_ROOT && root_done),
        .i_x0    (root),
        .i_y0    (y0),
        .o_done  (o_done),
        .o_angle (o_angle)
    );
endmodule
`default_nettype wire
